>>> src/slpa_pkg.sv
// ----------------------------------------------------------------------------
// slpa_pkg - shared definitions for the loop position advance unit
// Widths, register indexes, loop modes, end-of-item actions and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package slpa_pkg;

  localparam int FRAC_BITS_DEF = 32;

  localparam int POS_W      = 32;
  localparam int CNT_W      = 16;
  localparam int STEP_W     = 48;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int DIV_CNT_W  = 5;
  localparam int OP_W       = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DELTA  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_END  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE   = 3'd4;

  // loop modes; the two unused codes both behave as ping-pong
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FWD  = 2'd1;

  localparam logic [POS_W-1:0] LOOP_LEN_MIN = 32'd2;

  // action taken when an item is committed
  localparam logic [OP_W-1:0] OP_HOLD    = 3'd0;
  localparam logic [OP_W-1:0] OP_RESTART = 3'd1;
  localparam logic [OP_W-1:0] OP_PLAIN   = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd3;
  localparam logic [OP_W-1:0] OP_SHORT   = 3'd4;
  localparam logic [OP_W-1:0] OP_WRAP    = 3'd5;

  typedef struct packed {
    logic            capture;
    logic            mul;
    logic            fsum;
    logic            psum;
    logic            dinit;
    logic            dstep;
    logic            commit;
    logic [OP_W-1:0] op;
  } slpa_cmd_t;

  typedef struct packed {
    logic restart;
    logic active;
    logic at_end;
    logic no_loop;
    logic short_loop;
  } slpa_sts_t;

endpackage

>>> src/slpa_in_if.sv
// ----------------------------------------------------------------------------
// slpa_in_if - input item channel
// Valid/ready channel carrying one advance or restart item.
// ----------------------------------------------------------------------------
interface slpa_in_if
  import slpa_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [CNT_W-1:0] num_samples;
  logic [POS_W-1:0] start_position;

  modport source (output valid, kind, num_samples, start_position, input ready);
  modport sink   (input valid, kind, num_samples, start_position, output ready);
endinterface

>>> src/slpa_out_if.sv
// ----------------------------------------------------------------------------
// slpa_out_if - result channel
// Valid/ready channel carrying the voice state after each item.
// ----------------------------------------------------------------------------
interface slpa_out_if
  import slpa_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] out_position;
  logic [POS_W-1:0] out_fraction;
  logic             out_active;
  logic             out_looped;
  logic             out_backwards;

  modport source (output valid, out_position, out_fraction, out_active, out_looped,
                  out_backwards, input ready);
  modport sink   (input valid, out_position, out_fraction, out_active, out_looped,
                  out_backwards, output ready);
endinterface

>>> src/slpa_cfg_if.sv
// ----------------------------------------------------------------------------
// slpa_cfg_if - configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface slpa_cfg_if
  import slpa_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

>>> src/slpa_ctrl.sv
// ----------------------------------------------------------------------------
// slpa_ctrl - sequencer for the loop position advance unit
// Steps each item through multiply, sums, end check and the divider, and
// owns the input/output handshakes.
// ----------------------------------------------------------------------------
module slpa_ctrl
  import slpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  slpa_sts_t sts,
  output slpa_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_FSUM  = 3'd2;
  localparam logic [2:0] ST_PSUM  = 3'd3;
  localparam logic [2:0] ST_CHK   = 3'd4;
  localparam logic [2:0] ST_DINIT = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0]           state_r, state_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.op    = op_r;
    case (state_r)
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (sts.restart) begin
          op_nxt    = OP_RESTART;
          state_nxt = ST_FIN;
        end else if (!sts.active) begin
          op_nxt    = OP_HOLD;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_FSUM;
        end
      end
      ST_FSUM: begin
        cmd.fsum  = 1'b1;
        state_nxt = ST_PSUM;
      end
      ST_PSUM: begin
        cmd.psum  = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (!sts.at_end) begin
          op_nxt    = OP_PLAIN;
          state_nxt = ST_FIN;
        end else if (sts.no_loop) begin
          op_nxt    = OP_STOP;
          state_nxt = ST_FIN;
        end else if (sts.short_loop) begin
          op_nxt    = OP_SHORT;
          state_nxt = ST_FIN;
        end else begin
          op_nxt    = OP_WRAP;
          state_nxt = ST_DINIT;
        end
      end
      ST_DINIT: begin
        cmd.dinit = 1'b1;
        cnt_nxt   = '1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.dstep = 1'b1;
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register is free
        cmd.commit = out_free;
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit)     out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_HOLD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_MUL))
    else $error("accepted word did not start the sequence");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the commit step");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("commit would overwrite a waiting result");

  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r != '0) |=> (state_r == ST_DIV))
    else $error("divider left early");

  a_wrap_uses_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && op_r == OP_WRAP) |-> $past(state_r == ST_DIV || state_r == ST_FIN))
    else $error("wrap committed without a finished divide");
`endif

endmodule

>>> src/slpa_dp.sv
// ----------------------------------------------------------------------------
// slpa_dp - datapath for the loop position advance unit
// Config registers, voice state, fixed-point step products and sums, a
// restoring divider for the loop wrap, and the result register.
// ----------------------------------------------------------------------------
module slpa_dp
  import slpa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_kind,
  input  logic [CNT_W-1:0]      in_num_samples,
  input  logic [POS_W-1:0]      in_start_position,
  input  slpa_cmd_t             cmd,
  output slpa_sts_t             sts,
  output logic [POS_W-1:0]      out_position,
  output logic [POS_W-1:0]      out_fraction,
  output logic                  out_active,
  output logic                  out_looped,
  output logic                  out_backwards
);

  localparam int PFW = FRAC_BITS + CNT_W;
  localparam int FSW = PFW + 1;

  // configuration
  logic [STEP_W-1:0] step_delta_r;
  logic [POS_W-1:0]  sample_end_r, loop_start_r, loop_length_r;
  logic [MODE_W-1:0] loop_mode_r;

  // voice state
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;
  logic                 act_r, act_nxt;
  logic                 bwd_r, bwd_nxt;
  logic                 lpd_r, lpd_nxt;

  // working registers
  logic             kind_r;
  logic [CNT_W-1:0] count_r;
  logic [POS_W-1:0] start_r;
  logic [POS_W-1:0] prod_int_r;
  logic [PFW-1:0]   prod_frac_r;
  logic [FSW-1:0]   fsum_r;
  logic [POS_W-1:0] npos_r;
  logic [POS_W-1:0] rem_r, q_r;
  logic             qbit_r;

  logic [STEP_W-1:0]    step_hi;
  logic [POS_W-1:0]     int_step;
  logic [FRAC_BITS-1:0] frac_step;
  logic [POS_W:0]       div_shift, div_diff;
  logic                 div_ge;

  assign step_hi   = step_delta_r >> FRAC_BITS;
  assign int_step  = step_hi[POS_W-1:0];
  assign frac_step = step_delta_r[FRAC_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_delta_r  <= '0;
      sample_end_r  <= '0;
      loop_start_r  <= '0;
      loop_length_r <= '0;
      loop_mode_r   <= MODE_NONE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STEP_DELTA:  step_delta_r  <= cfg_data;
        REG_SAMPLE_END:  sample_end_r  <= cfg_data[POS_W-1:0];
        REG_LOOP_START:  loop_start_r  <= cfg_data[POS_W-1:0];
        REG_LOOP_LENGTH: loop_length_r <= cfg_data[POS_W-1:0];
        REG_LOOP_MODE:   loop_mode_r   <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign div_shift = {rem_r, q_r[POS_W-1]};
  assign div_ge    = div_shift >= {1'b0, loop_length_r};
  assign div_diff  = div_shift - {1'b0, loop_length_r};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_kind;
      count_r <= in_num_samples;
      start_r <= in_start_position;
    end
    if (cmd.mul) begin
      prod_int_r  <= int_step * POS_W'(count_r);
      prod_frac_r <= PFW'(frac_step) * PFW'(count_r);
    end
    if (cmd.fsum) fsum_r <= FSW'(prod_frac_r) + FSW'(frac_r);
    if (cmd.psum) npos_r <= pos_r + prod_int_r + POS_W'(fsum_r[FSW-1:FRAC_BITS]);
    if (cmd.dinit) begin
      rem_r <= '0;
      q_r   <= npos_r - sample_end_r;
    end
    if (cmd.dstep) begin
      rem_r  <= div_ge ? div_diff[POS_W-1:0] : div_shift[POS_W-1:0];
      q_r    <= {q_r[POS_W-2:0], 1'b0};
      qbit_r <= div_ge;  // after the last step this is the quotient lsb
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    frac_nxt = frac_r;
    act_nxt  = act_r;
    bwd_nxt  = bwd_r;
    lpd_nxt  = lpd_r;
    case (cmd.op)
      OP_RESTART: begin
        pos_nxt  = start_r;
        frac_nxt = '0;
        act_nxt  = 1'b1;
        bwd_nxt  = 1'b0;
        lpd_nxt  = 1'b0;
      end
      OP_PLAIN: begin
        pos_nxt  = npos_r;
        frac_nxt = fsum_r[FRAC_BITS-1:0];
      end
      OP_STOP: act_nxt = 1'b0;
      OP_SHORT: begin
        pos_nxt  = loop_start_r;
        frac_nxt = fsum_r[FRAC_BITS-1:0];
        lpd_nxt  = 1'b1;
      end
      OP_WRAP: begin
        pos_nxt  = loop_start_r + rem_r;
        frac_nxt = fsum_r[FRAC_BITS-1:0];
        lpd_nxt  = 1'b1;
        // ping-pong flips on an even number of whole passes
        if (loop_mode_r != MODE_FWD && !qbit_r) bwd_nxt = !bwd_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      frac_r <= '0;
      act_r  <= 1'b0;
      bwd_r  <= 1'b0;
      lpd_r  <= 1'b0;
    end else if (cmd.commit) begin
      pos_r  <= pos_nxt;
      frac_r <= frac_nxt;
      act_r  <= act_nxt;
      bwd_r  <= bwd_nxt;
      lpd_r  <= lpd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_position  <= pos_nxt;
      out_fraction  <= POS_W'(frac_nxt);
      out_active    <= act_nxt;
      out_looped    <= lpd_nxt;
      out_backwards <= bwd_nxt;
    end
  end

  assign sts.restart    = kind_r;
  assign sts.active     = act_r;
  assign sts.at_end     = npos_r >= sample_end_r;
  assign sts.no_loop    = loop_mode_r == MODE_NONE;
  assign sts.short_loop = loop_length_r < LOOP_LEN_MIN;

endmodule

>>> src/sample_loop_position_advance_unit.sv
// ----------------------------------------------------------------------------
// sample_loop_position_advance_unit - silent voice position advance
// Moves a voice's fixed-point playback position by step times sample count
// and handles end of sample: stop, forward loop or ping-pong loop.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one word per item; kind 0 advances by num_samples, kind 1
//            restarts the voice at start_position.
//   out_ch : one word per item with the voice state after that item.
//   cfg_ch : register writes (step_delta, sample_end, loop_start,
//            loop_length, loop_mode), always ready; write only while idle.
// Timing: one item at a time. Restart or an advance of an inactive voice
// goes from the multiply step to commit; an advance that stays in the sample,
// stops or meets a too-short loop also runs the sums and end check; a wrap
// adds the 32-step restoring divider that folds the overshoot into the loop.
// A new word is accepted once the previous item has committed, even while its
// result still waits in the output register; if the receiver stalls, the next
// item completes and then holds until that register is taken.
// Reset (rst_n low, synchronous) clears config and leaves the voice inactive.
// ----------------------------------------------------------------------------
module sample_loop_position_advance_unit
  import slpa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  slpa_in_if.sink    in_ch,
  slpa_out_if.source out_ch,
  slpa_cfg_if.sink   cfg_ch
);

  slpa_cmd_t cmd;
  slpa_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  slpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  slpa_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_ch.valid),
    .cfg_index         (cfg_ch.reg_index),
    .cfg_data          (cfg_ch.wdata),
    .in_kind           (in_ch.kind),
    .in_num_samples    (in_ch.num_samples),
    .in_start_position (in_ch.start_position),
    .cmd               (cmd),
    .sts               (sts),
    .out_position      (out_ch.out_position),
    .out_fraction      (out_ch.out_fraction),
    .out_active        (out_ch.out_active),
    .out_looped        (out_ch.out_looped),
    .out_backwards     (out_ch.out_backwards)
  );

endmodule
